// ===== rtl/core/etrr_pkg.sv =====
// Package for the edge timestamp record and replay block.
// Holds the mode codes, the control state type and default sizes.
// No dependencies; compile first.
package etrr_pkg;

    // Default sizes of the timestamp tables and the tick counter
    localparam int TABLE_DEPTH_DEF = 128;
    localparam int TICK_WIDTH_DEF  = 32;

    // Width of the duration register
    localparam int CFG_WIDTH = 32;

    // Request mode codes
    typedef enum logic [1:0] {
        MODE_START_REC  = 2'd0,
        MODE_REC_TICK   = 2'd1,
        MODE_START_PLAY = 2'd2,
        MODE_PLAY_TICK  = 2'd3
    } mode_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } etrr_state_t;

endpackage

// ===== rtl/core/etrr_in_if.sv =====
// Request channel of the edge timestamp record and replay block.
// Depends on etrr_pkg for the mode type.
interface etrr_in_if import etrr_pkg::*;;
    logic  valid;
    logic  ready;
    mode_t mode;
    logic  button_level;

    modport source (output valid, output mode, output button_level, input ready);
    modport sink   (input valid, input mode, input button_level, output ready);
endinterface

// ===== rtl/core/etrr_out_if.sv =====
// Result channel of the edge timestamp record and replay block.
// No dependencies beyond the package order.
interface etrr_out_if;
    logic valid;
    logic ready;
    logic led_on;
    logic phase_done;
    logic table_overflow;

    modport source (output valid, output led_on, output phase_done,
                    output table_overflow, input ready);
    modport sink   (input valid, input led_on, input phase_done,
                    input table_overflow, output ready);
endinterface

// ===== rtl/core/etrr_tbl_mem.sv =====
// Timestamp table: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. Uses etrr_pkg.
module etrr_tbl_mem import etrr_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int WIDTH = TICK_WIDTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Store a timestamp
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read every cycle into the output register
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/edge_timestamp_record_replay.sv =====
// Edge timestamp record and replay: top level with sequencer and state update.
// The result is registered and becomes valid once the accepted request executes;
// execution waits while an earlier result is still held. A new request is taken
// only in idle, after the previous one has gone through the registered table read
// that precedes every state update. Reset: counters, flags, LED and the duration
// register clear at once; the tables are not cleared and only entries below the recorded count are used.
module edge_timestamp_record_replay import etrr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] cfg_wr_data,
    etrr_in_if.sink              in_req,
    etrr_out_if.source           out_res
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    etrr_state_t           state_reg, state_next;
    logic [CFG_WIDTH-1:0]  duration_reg;
    mode_t                 mode_reg;
    logic                  level_reg;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic                  prev_reg, prev_next;
    logic [CNT_W-1:0]      press_rec_reg, press_rec_next;
    logic [CNT_W-1:0]      rel_rec_reg, rel_rec_next;
    logic [CNT_W-1:0]      press_idx_reg, press_idx_next;
    logic [CNT_W-1:0]      rel_idx_reg, rel_idx_next;
    logic                  led_reg, led_next;
    logic                  ovf_reg, ovf_next;
    logic                  over_reg, over_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  commit;
    logic                  tick_last;
    logic                  press_wr_en, rel_wr_en;
    logic [TICK_WIDTH-1:0] press_rd_data, rel_rd_data;

    // Timestamp tables
    etrr_tbl_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(TICK_WIDTH)) u_press_mem (
        .clk     (clk),
        .wr_en   (press_wr_en),
        .wr_addr (press_rec_reg[ADDR_W-1:0]),
        .wr_data (tick_reg),
        .rd_addr (press_idx_reg[ADDR_W-1:0]),
        .rd_data (press_rd_data)
    );

    etrr_tbl_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(TICK_WIDTH)) u_rel_mem (
        .clk     (clk),
        .wr_en   (rel_wr_en),
        .wr_addr (rel_rec_reg[ADDR_W-1:0]),
        .wr_data (tick_reg),
        .rd_addr (rel_idx_reg[ADDR_W-1:0]),
        .rd_data (rel_rd_data)
    );

    // Update state once the table read has landed and the result slot is free
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || out_res.ready);
    assign tick_last = (tick_reg == TICK_WIDTH'(duration_reg));

    always_comb
    begin
        tick_next      = tick_reg;
        prev_next      = prev_reg;
        press_rec_next = press_rec_reg;
        rel_rec_next   = rel_rec_reg;
        press_idx_next = press_idx_reg;
        rel_idx_next   = rel_idx_reg;
        led_next       = led_reg;
        ovf_next       = ovf_reg;
        over_next      = over_reg;
        press_wr_en    = 1'b0;
        rel_wr_en      = 1'b0;

        if (commit)
        begin
            case (mode_reg)
                MODE_START_REC:
                begin
                    tick_next      = '0;
                    prev_next      = 1'b0;
                    press_rec_next = '0;
                    rel_rec_next   = '0;
                    ovf_next       = 1'b0;
                    over_next      = 1'b0;
                end
                MODE_REC_TICK:
                begin
                    if (!over_reg)
                    begin
                        // Record a press or release, drop it when the table is full
                        if (level_reg && !prev_reg)
                        begin
                            if (press_rec_reg < DEPTH_CNT)
                            begin
                                press_wr_en    = 1'b1;
                                press_rec_next = press_rec_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            led_next = 1'b1;
                        end
                        else if (!level_reg && prev_reg)
                        begin
                            if (rel_rec_reg < DEPTH_CNT)
                            begin
                                rel_wr_en    = 1'b1;
                                rel_rec_next = rel_rec_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            led_next = 1'b0;
                        end
                        prev_next = level_reg;
                        if (tick_last)
                        begin
                            over_next = 1'b1;
                        end
                        else
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                MODE_START_PLAY:
                begin
                    tick_next      = '0;
                    press_idx_next = '0;
                    rel_idx_next   = '0;
                    over_next      = 1'b0;
                    led_next       = 1'b1;
                end
                MODE_PLAY_TICK:
                begin
                    if (!over_reg)
                    begin
                        // Press first, so a release at the same tick leaves it dark
                        if ((press_idx_reg < press_rec_reg) && (press_rd_data == tick_reg))
                        begin
                            led_next       = 1'b1;
                            press_idx_next = press_idx_reg + 1'b1;
                        end
                        if ((rel_idx_reg < rel_rec_reg) && (rel_rd_data == tick_reg))
                        begin
                            led_next     = 1'b0;
                            rel_idx_next = rel_idx_reg + 1'b1;
                        end
                        if (tick_last)
                        begin
                            over_next = 1'b1;
                        end
                        else
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    over_next = over_reg;
                end
            endcase
        end
    end

    // Sequencer: take a request in idle, execute it in ST_EXEC once the result slot is free
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            duration_reg  <= '0;
            tick_reg      <= '0;
            prev_reg      <= 1'b0;
            press_rec_reg <= '0;
            rel_rec_reg   <= '0;
            press_idx_reg <= '0;
            rel_idx_reg   <= '0;
            led_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            prev_reg      <= prev_next;
            press_rec_reg <= press_rec_next;
            rel_rec_reg   <= rel_rec_next;
            press_idx_reg <= press_idx_next;
            rel_idx_reg   <= rel_idx_next;
            led_reg       <= led_next;
            ovf_reg       <= ovf_next;
            over_reg      <= over_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                duration_reg <= cfg_wr_data;
            end
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_req.valid && in_req.ready)
        begin
            mode_reg  <= in_req.mode;
            level_reg <= in_req.button_level;
        end
    end

    assign in_req.ready           = (state_reg == ST_IDLE);
    assign out_res.valid          = out_valid_reg;
    assign out_res.led_on         = led_reg;
    assign out_res.phase_done     = over_reg;
    assign out_res.table_overflow = ovf_reg;

    // Recorded counts never pass the table depth
    a_rec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (press_rec_reg <= DEPTH_CNT) && (rel_rec_reg <= DEPTH_CNT))
        else $error("recorded count beyond table depth");

    // An executed request always leaves a result behind
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("executed request produced no result");

    // Overflow only rises on a record tick
    a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> ($past(commit) && ($past(mode_reg) == MODE_REC_TICK)))
        else $error("overflow set outside a record tick");

    // No table write outside the execute state
    a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (press_wr_en || rel_wr_en) |-> (state_reg == ST_EXEC))
        else $error("table written outside execution");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for edge_timestamp_record_replay: drives record and replay requests,
// predicts each LED result from its own model of the block and checks them in order.
// Depends on etrr_pkg, etrr_in_if, etrr_out_if and the block itself.
module testbench;
    import etrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_TARGET  = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AFTER     = 60;

    typedef struct packed {
        mode_t mode;
        logic  level;
    } led_req_t;

    typedef struct packed {
        logic led_on;
        logic phase_done;
        logic table_overflow;
    } led_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_WIDTH-1:0] cfg_wr_data;

    etrr_in_if  req_if ();
    etrr_out_if res_if ();

    edge_timestamp_record_replay u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_req      (req_if),
        .out_res     (res_if)
    );

    // Requests waiting to be offered and LED results waiting to arrive
    led_req_t queued_ticks [$];
    led_res_t expected_led [$];

    int mismatch_cnt = 0;
    int req_acc_cnt  = 0;
    int res_cnt      = 0;
    int idle_cycles  = 0;
    int rand_items   = 0;
    logic hold_off   = 1'b0;

    // Model state of the block
    logic [TICK_WIDTH_DEF-1:0] dur_model;
    logic [TICK_WIDTH_DEF-1:0] tick_ctr;
    logic [TICK_WIDTH_DEF-1:0] press_tab   [TABLE_DEPTH_DEF];
    logic [TICK_WIDTH_DEF-1:0] release_tab [TABLE_DEPTH_DEF];
    int   press_cnt, release_cnt, press_ptr, release_ptr;
    logic prev_btn, led_lvl, ovf_flag, phase_over;

    // Driver and monitor working variables
    led_req_t cur_req;
    logic     offer;
    int       send_gap   = 0;
    logic     send_burst = 1'b0;
    int       rdy_wait   = 0;
    logic     recv_burst = 1'b0;
    led_res_t got, want;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the current tick: mark the phase over or advance the counter
    function automatic void close_tick();
        if (tick_ctr == dur_model)
            phase_over = 1'b1;
        else
            tick_ctr = tick_ctr + 1'b1;
    endfunction

    // Apply one request to the model and return the LED result it gives
    function automatic led_res_t predict_led(input led_req_t req);
        led_res_t r;
        case (req.mode)
            MODE_START_REC:
            begin
                tick_ctr    = '0;
                prev_btn    = 1'b0;
                press_cnt   = 0;
                release_cnt = 0;
                ovf_flag    = 1'b0;
                phase_over  = 1'b0;
            end
            MODE_REC_TICK:
            begin
                if (!phase_over)
                begin
                    if (req.level && !prev_btn)
                    begin
                        if (press_cnt < TABLE_DEPTH_DEF)
                        begin
                            press_tab[press_cnt] = tick_ctr;
                            press_cnt++;
                        end
                        else
                            ovf_flag = 1'b1;
                        led_lvl = 1'b1;
                    end
                    else if (!req.level && prev_btn)
                    begin
                        if (release_cnt < TABLE_DEPTH_DEF)
                        begin
                            release_tab[release_cnt] = tick_ctr;
                            release_cnt++;
                        end
                        else
                            ovf_flag = 1'b1;
                        led_lvl = 1'b0;
                    end
                    prev_btn = req.level;
                    close_tick();
                end
            end
            MODE_START_PLAY:
            begin
                tick_ctr    = '0;
                press_ptr   = 0;
                release_ptr = 0;
                phase_over  = 1'b0;
                led_lvl     = 1'b1;
            end
            default:
            begin
                if (!phase_over)
                begin
                    // Press goes first, so a release at the same tick wins
                    if (press_ptr < press_cnt && press_tab[press_ptr] == tick_ctr)
                    begin
                        led_lvl = 1'b1;
                        press_ptr++;
                    end
                    if (release_ptr < release_cnt && release_tab[release_ptr] == tick_ctr)
                    begin
                        led_lvl = 1'b0;
                        release_ptr++;
                    end
                    close_tick();
                end
            end
        endcase
        r.led_on         = led_lvl;
        r.phase_done     = phase_over;
        r.table_overflow = ovf_flag;
        return r;
    endfunction

    // Request driver: offer queued requests with random gaps, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid        <= 1'b0;
            req_if.mode         <= MODE_START_REC;
            req_if.button_level <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            offer = req_if.valid;
            if (req_if.valid && req_if.ready)
            begin
                expected_led.push_back(predict_led(cur_req));
                req_acc_cnt++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (queued_ticks.size() > 0)
                begin
                    cur_req = queued_ticks.pop_front();
                    req_if.mode         <= cur_req.mode;
                    req_if.button_level <= cur_req.level;
                    offer = 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 4);
                end
            end
            req_if.valid <= offer;
        end
    end

    // Result monitor: check each result against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            rdy_wait = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = '{res_if.led_on, res_if.phase_done, res_if.table_overflow};
                if (expected_led.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result %0d not expected: led=%b done=%b ovf=%b",
                                 res_cnt, got.led_on, got.phase_done, got.table_overflow);
                end
                else
                begin
                    want = expected_led.pop_front();
                    if (got.led_on !== want.led_on || got.phase_done !== want.phase_done ||
                        got.table_overflow !== want.table_overflow)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"result %0d: expected led=%b done=%b ovf=%b, ",
                                      "got led=%b done=%b ovf=%b"},
                                     res_cnt, want.led_on, want.phase_done,
                                     want.table_overflow, got.led_on, got.phase_done,
                                     got.table_overflow);
                    end
                end
                res_cnt++;
                if ($urandom_range(0, 19) == 0)
                    recv_burst = !recv_burst;
                rdy_wait = recv_burst ? 0 : $urandom_range(0, 4);
            end
            else if (!res_if.ready && rdy_wait > 0)
                rdy_wait--;
            res_if.ready <= !hold_off && rdy_wait == 0;
        end
    end

    // Hold the result side off for a long stretch once traffic is flowing
    initial
    begin
        wait (req_acc_cnt >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: count cycles with work outstanding and nothing accepted
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (queued_ticks.size() == 0 && !req_if.valid && expected_led.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_req(input mode_t mode, input logic level);
        queued_ticks.push_back('{mode, level});
    endtask

    // Wait until every request is accepted and every result has arrived
    task automatic settle();
        do
            @(negedge clk);
        while (queued_ticks.size() != 0 || req_if.valid || expected_led.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the duration register; call only while the block is idle
    task automatic set_duration(input logic [CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        dur_model = value;
        @(negedge clk);
    endtask

    // One record then replay session with random content and occasional noise
    task automatic random_session();
        logic [CFG_WIDTH-1:0] dur;
        int   pick, n, m;
        logic lvl;
        dur = dur_model;
        if ($urandom_range(0, 2) != 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                dur = '0;
            else if (pick == 1)
                dur = '1;
            else if (pick == 2)
                dur = $urandom;
            else
                dur = $urandom_range(1, 24);
            settle();
            set_duration(dur);
        end
        n = (dur < 25) ? $urandom_range(0, dur + 3) : $urandom_range(1, 24);
        if ($urandom_range(0, 7) != 0)
            push_req(MODE_START_REC, $urandom_range(0, 1));
        lvl = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1));
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    lvl = !lvl;
                push_req(MODE_REC_TICK, lvl);
            end
        end
        push_req(MODE_START_PLAY, $urandom_range(0, 1));
        m = n + $urandom_range(0, 3);
        for (int i = 0; i < m; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1));
            else
                push_req(MODE_PLAY_TICK, $urandom_range(0, 1));
        end
        rand_items += 2 * n + 2;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        req_if.valid        = 1'b0;
        req_if.mode         = MODE_START_REC;
        req_if.button_level = 1'b0;
        res_if.ready        = 1'b0;

        // Model state after reset
        dur_model   = '0;
        tick_ctr    = '0;
        prev_btn    = 1'b0;
        press_cnt   = 0;
        release_cnt = 0;
        press_ptr   = 0;
        release_ptr = 0;
        led_lvl     = 1'b0;
        ovf_flag    = 1'b0;
        phase_over  = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset duration of zero: ticks without a start, ticks after the phase is over
        push_req(MODE_REC_TICK, 1'b1);
        push_req(MODE_REC_TICK, 1'b0);
        push_req(MODE_PLAY_TICK, 1'b1);
        push_req(MODE_START_PLAY, 1'b0);
        push_req(MODE_PLAY_TICK, 1'b0);
        settle();

        // Press and release stored at the same tick: that replay tick must leave the LED dark
        set_duration(32'd3);
        push_req(MODE_START_REC, 1'b0);
        push_req(MODE_REC_TICK, 1'b1);
        push_req(MODE_START_PLAY, 1'b0);
        push_req(MODE_REC_TICK, 1'b0);
        push_req(MODE_REC_TICK, 1'b1);
        push_req(MODE_START_PLAY, 1'b1);
        for (int i = 0; i < 5; i++)
            push_req(MODE_PLAY_TICK, i[0]);
        settle();

        // Longest duration: the phase never ends within the run
        set_duration('1);
        push_req(MODE_START_REC, 1'b1);
        push_req(MODE_REC_TICK, 1'b1);
        push_req(MODE_REC_TICK, 1'b1);
        push_req(MODE_REC_TICK, 1'b0);
        push_req(MODE_START_PLAY, 1'b1);
        push_req(MODE_PLAY_TICK, 1'b0);
        push_req(MODE_PLAY_TICK, 1'b1);
        push_req(MODE_PLAY_TICK, 1'b0);
        settle();

        // Fill both tables past their depth, replay the start, then clear the flag
        set_duration(32'd300);
        push_req(MODE_START_REC, 1'b0);
        for (int i = 0; i < 2 * TABLE_DEPTH_DEF + 2; i++)
            push_req(MODE_REC_TICK, !i[0]);
        push_req(MODE_START_PLAY, 1'b0);
        for (int i = 0; i < 40; i++)
            push_req(MODE_PLAY_TICK, $urandom_range(0, 1));
        push_req(MODE_START_REC, 1'b1);
        push_req(MODE_REC_TICK, 1'b1);
        settle();

        set_duration('0);
        push_req(MODE_START_REC, 1'b0);
        push_req(MODE_REC_TICK, 1'b1);
        push_req(MODE_START_PLAY, 1'b0);
        push_req(MODE_PLAY_TICK, 1'b0);

        while (rand_items < RANDOM_TARGET)
            random_session();
        settle();

        if (mismatch_cnt == 0 && expected_led.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
